### rtl/core/scwl_pkg.sv
// Shared constants and helper functions for the word lookup block.
`timescale 1ns / 1ps
package scwl_pkg;
	localparam int MAX_WORD_DEF   = 32;
	localparam int DICT_BYTES_DEF = 65536;
	localparam logic [7:0] CH_UA = 8'h41;
	localparam logic [7:0] CH_UZ = 8'h5A;
	localparam logic [7:0] CH_LA = 8'h61;
	localparam logic [7:0] CH_LZ = 8'h7A;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [1:0] ACT_DICT  = 2'd0;
	localparam logic [1:0] ACT_ART   = 2'd1;
	localparam logic [1:0] ACT_END   = 2'd2;
	localparam logic [1:0] ACT_CLEAR = 2'd3;

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c >= CH_UA && c <= CH_UZ) ? c + CH_SP : c;
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ);
	endfunction
endpackage

### rtl/core/spell_check_word_lookup_top.sv
// Top level: dictionary store, word buffer and lookup sequencer.
// Dictionary, letter and clear transactions finish in the accepting cycle; a word
// end keeps busy high while it scans each dictionary byte (ST_SCAN read, ST_CMP compare),
// then ST_RD/ST_RPT per reported character, ST_RD/ST_NL for the newline (length + 1 results).
// Throughput: one transaction at a time; the receiver cannot stall, results last one cycle.
// Reset (arst_n low): fill, word length, overflow cleared; min length 2.
`timescale 1ns / 1ps
module spell_check_word_lookup_top #(
	parameter int MAX_WORD   = scwl_pkg::MAX_WORD_DEF,
	parameter int DICT_BYTES = scwl_pkg::DICT_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] action,
	input  logic [7:0] character,
	input  logic       cfg_we,
	input  logic [5:0] cfg_wdata,
	output logic       strobe,
	output logic [7:0] out_char,
	output logic       last,
	output logic       truncated
);
	localparam int DAW = $clog2(DICT_BYTES);
	localparam int FW  = $clog2(DICT_BYTES + 1);
	localparam int WAW = $clog2(MAX_WORD);
	localparam int LW  = $clog2(MAX_WORD + 1);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_SCAN = 6'b000010,
		ST_CMP  = 6'b000100,
		ST_RPT  = 6'b001000,
		ST_RD   = 6'b010000,
		ST_NL   = 6'b100000
	} state_t;

	state_t         state_q;
	logic [FW-1:0]  fill_q;
	logic [LW-1:0]  wlen_q, k_q, ri_q;
	logic           ovf_q, ok_q;
	logic [5:0]     minlen_q;
	logic [DAW-1:0] di_q;

	logic           d_we, w_we;
	logic [DAW-1:0] d_addr;
	logic [WAW-1:0] w_addr;
	logic [7:0]     d_rd, w_rd;

	wire acc = start && (state_q == ST_IDLE);
	wire is_l = scwl_pkg::is_letter(character);
	wire fin = acc && (action == scwl_pkg::ACT_END ||
		(action == scwl_pkg::ACT_ART && !is_l));
	wire [5:0] eff_min = (minlen_q == 6'd0) ? 6'd1 : minlen_q;
	wire do_scan = wlen_q != '0 && 32'(eff_min) <= 32'(wlen_q);

	assign d_we = acc && action == scwl_pkg::ACT_DICT && fill_q < FW'(DICT_BYTES);
	assign d_addr = d_we ? fill_q[DAW-1:0] : di_q;
	assign w_we = acc && action == scwl_pkg::ACT_ART && is_l && wlen_q < LW'(MAX_WORD);
	assign w_addr = w_we ? wlen_q[WAW-1:0] :
		((state_q == ST_SCAN || state_q == ST_CMP) ? k_q[WAW-1:0] : ri_q[WAW-1:0]);

	scwl_ram #(.WIDTH(8), .DEPTH(DICT_BYTES)) u_dict (
		.clk(clk), .we(d_we), .addr(d_addr),
		.wdata(scwl_pkg::to_lower(character)), .rdata(d_rd));
	scwl_ram #(.WIDTH(8), .DEPTH(MAX_WORD)) u_word (
		.clk(clk), .we(w_we), .addr(w_addr),
		.wdata(scwl_pkg::to_lower(character)), .rdata(w_rd));

	// Scan: ST_SCAN issues dictionary read di and word read k; ST_CMP compares.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE; fill_q <= '0; wlen_q <= '0; ovf_q <= 1'b0;
			minlen_q <= 6'd2; di_q <= '0; k_q <= '0; ri_q <= '0; ok_q <= 1'b1;
		end else begin
			if (cfg_we) minlen_q <= cfg_wdata;
			case (state_q)
				ST_IDLE: begin
					if (d_we) fill_q <= fill_q + 1'b1;
					if (acc && action == scwl_pkg::ACT_CLEAR) fill_q <= '0;
					if (acc && action == scwl_pkg::ACT_ART && is_l) begin
						if (w_we) wlen_q <= wlen_q + 1'b1;
						else ovf_q <= 1'b1;
					end
					if (fin) begin
						di_q <= '0; k_q <= '0; ok_q <= 1'b1; ri_q <= '0;
						if (ovf_q) state_q <= ST_RD;
						else if (do_scan && fill_q != '0) state_q <= ST_SCAN;
						else if (do_scan) state_q <= ST_RD;
						else wlen_q <= '0;
					end
				end
				ST_SCAN: state_q <= ST_CMP;
				ST_CMP: begin
					if (d_rd == scwl_pkg::CH_NL) begin
						if (ok_q && k_q == wlen_q) begin
							state_q <= ST_IDLE; wlen_q <= '0; ovf_q <= 1'b0;
						end
						ok_q <= 1'b1; k_q <= '0;
					end else if (ok_q && k_q < wlen_q && d_rd == w_rd) begin
						k_q <= k_q + 1'b1;
					end else ok_q <= 1'b0;
					if (!(d_rd == scwl_pkg::CH_NL && ok_q && k_q == wlen_q)) begin
						if ({{(FW-DAW){1'b0}}, di_q} + 1'b1 >= fill_q) begin
							state_q <= ST_RD; ri_q <= '0;
						end else begin
							di_q <= di_q + 1'b1; state_q <= ST_SCAN;
						end
					end
				end
				ST_RD: state_q <= (ri_q < wlen_q) ? ST_RPT : ST_NL;
				ST_RPT: begin
					ri_q <= ri_q + 1'b1;
					state_q <= ST_RD;
				end
				ST_NL: begin
					state_q <= ST_IDLE; wlen_q <= '0; ovf_q <= 1'b0;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = state_q != ST_IDLE;
	assign strobe = state_q == ST_RPT || state_q == ST_NL;
	assign out_char = state_q == ST_NL ? scwl_pkg::CH_NL : w_rd;
	assign last = state_q == ST_NL;
	assign truncated = ovf_q && strobe;

`ifndef SYNTH
	a_nl_ends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_NL |=> state_q == ST_IDLE && wlen_q == '0)
		else $error("newline did not close the word");
	a_no_acc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy) else $error("result outside busy");
	a_wlen: assert property (@(posedge clk) disable iff (!arst_n)
		wlen_q <= LW'(MAX_WORD)) else $error("word length overflow");
`endif
endmodule

### rtl/core/scwl_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module scwl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

### bench/spell_check_word_lookup_top_tb.sv
// Testbench for the dictionary word lookup block: directed, config and random tests.
`timescale 1ns / 1ps
module spell_check_word_lookup_top_tb;
	localparam int WORD_CAP   = 32;
	localparam int DICT_CAP   = 65536;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic [7:0] ch;
		logic       lst;
		logic       tr;
	} report_t;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [1:0] action;
	logic [7:0] character;
	logic       cfg_we;
	logic [5:0] cfg_wdata;
	logic       strobe;
	logic [7:0] out_char;
	logic       last;
	logic       truncated;

	// lookup mirror
	logic [7:0] dict_mem [DICT_CAP];
	int unsigned fill_cnt;
	logic [7:0] word_mem [WORD_CAP];
	int unsigned word_len;
	bit word_cut;
	logic [5:0] min_len;

	report_t report_q [$];
	string known_words [$];
	int errors;
	int cycles;
	int send_idle_pct;

	spell_check_word_lookup_top i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .character(character),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.strobe(strobe), .out_char(out_char), .last(last), .truncated(truncated)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic bit letter_byte(logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic logic [7:0] fold_case(logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
	endfunction

	function automatic bit word_in_dict();
		int unsigned k;
		bit ok;
		k = 0;
		ok = 1;
		for (int unsigned i = 0; i < fill_cnt; i++) begin
			if (dict_mem[i] == scwl_pkg::CH_NL) begin
				if (ok && k == word_len)
					return 1;
				ok = 1;
				k = 0;
			end else if (ok && k < word_len && dict_mem[i] == word_mem[k]) begin
				k++;
			end else begin
				ok = 0;
			end
		end
		return 0;
	endfunction

	function automatic void close_word();
		bit flag;
		flag = 0;
		if (word_cut)
			flag = 1;
		else if (word_len > 0 && word_len >= min_len)
			flag = !word_in_dict();
		if (flag) begin
			for (int unsigned i = 0; i < word_len; i++)
				report_q.push_back('{word_mem[i], 1'b0, word_cut});
			report_q.push_back('{scwl_pkg::CH_NL, 1'b1, word_cut});
		end
		word_len = 0;
		word_cut = 0;
	endfunction

	function automatic void predict(logic [1:0] act, logic [7:0] c);
		case (act)
			scwl_pkg::ACT_DICT: begin
				if (fill_cnt < DICT_CAP) begin
					dict_mem[fill_cnt] = fold_case(c);
					fill_cnt++;
				end
			end
			scwl_pkg::ACT_ART: begin
				if (letter_byte(c)) begin
					if (word_len < WORD_CAP) begin
						word_mem[word_len] = fold_case(c);
						word_len++;
					end else begin
						word_cut = 1;
					end
				end else begin
					close_word();
				end
			end
			scwl_pkg::ACT_END: close_word();
			default: fill_cnt = 0;
		endcase
	endfunction

	// compare each strobed result with the oldest expectation
	always @(posedge clk) begin
		report_t got, want;
		if (arst_n && strobe) begin
			got = '{out_char, last, truncated};
			if (report_q.size() == 0) begin
				$display("%0t: unexpected result expected none actual %h/%b/%b",
					$time, out_char, last, truncated);
				errors++;
			end else begin
				want = report_q.pop_front();
				if (got.ch !== want.ch) begin
					$display("%0t: out_char expected %h actual %h", $time, want.ch, got.ch);
					errors++;
				end
				if (got.lst !== want.lst) begin
					$display("%0t: last expected %b actual %b", $time, want.lst, got.lst);
					errors++;
				end
				if (got.tr !== want.tr) begin
					$display("%0t: truncated expected %b actual %b", $time, want.tr, got.tr);
					errors++;
				end
			end
		end
	end

	task automatic send_item(logic [1:0] act, logic [7:0] c);
		if ($urandom_range(99) < send_idle_pct)
			repeat ($urandom_range(1, 6)) @(negedge clk);
		@(negedge clk);
		start = 1'b1;
		action = act;
		character = c;
		do @(posedge clk); while (busy);
		predict(act, c);
		@(negedge clk);
		start = 1'b0;
		character = 8'($urandom_range(255));
	endtask

	task automatic send_text(logic [1:0] act, string s);
		for (int i = 0; i < s.len(); i++)
			send_item(act, s[i]);
	endtask

	// wait for every expected result and for the block to go idle
	task automatic drain();
		while (report_q.size() != 0)
			@(posedge clk);
		do @(posedge clk); while (busy);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_min_len(logic [5:0] v);
		drain();
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		min_len = v;
	endtask

	function automatic logic [7:0] rand_letter();
		logic [7:0] c;
		c = 8'($urandom_range(0, 25));
		return $urandom_range(1) ? 8'h41 + c : 8'h61 + c;
	endfunction

	function automatic logic [7:0] rand_separator();
		logic [7:0] c;
		do c = 8'($urandom_range(255)); while (letter_byte(c));
		return c;
	endfunction

	function automatic string rand_word(int n);
		string s;
		s = "";
		for (int i = 0; i < n; i++)
			s = {s, string'(8'h61 + 8'($urandom_range(0, 3)))};
		return s;
	endfunction

	task automatic test_directed();
		send_text(scwl_pkg::ACT_DICT, "cat\nDog\na\n");
		send_item(scwl_pkg::ACT_DICT, 8'h00);
		send_item(scwl_pkg::ACT_DICT, 8'hFF);
		send_item(scwl_pkg::ACT_DICT, scwl_pkg::CH_NL);
		send_text(scwl_pkg::ACT_ART, "cat DOG.cow,a Zebra!");
		send_item(scwl_pkg::ACT_ART, 8'h40);
		send_text(scwl_pkg::ACT_ART, "Az");
		send_item(scwl_pkg::ACT_ART, 8'h5B);
		send_item(scwl_pkg::ACT_ART, 8'h7B);
		send_text(scwl_pkg::ACT_ART, "abcdefghijklmnopqrstuvwxyzABCDEFGHIJ");
		send_item(scwl_pkg::ACT_END, 8'h00);
		send_item(scwl_pkg::ACT_END, 8'h00);
		// the dictionary may change while a word is pending
		send_text(scwl_pkg::ACT_ART, "ba");
		send_text(scwl_pkg::ACT_DICT, "BAT\n");
		send_text(scwl_pkg::ACT_ART, "t");
		send_item(scwl_pkg::ACT_ART, 8'h60);
		send_item(scwl_pkg::ACT_CLEAR, 8'h00);
		send_text(scwl_pkg::ACT_ART, "cat ");
		send_text(scwl_pkg::ACT_DICT, "end");
		send_text(scwl_pkg::ACT_ART, "end ");
		send_item(scwl_pkg::ACT_CLEAR, 8'h00);
		drain();
	endtask

	task automatic test_min_length();
		logic [5:0] settings [6] = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd3, 6'd2};
		send_text(scwl_pkg::ACT_DICT, "ab\n");
		foreach (settings[i]) begin
			write_min_len(settings[i]);
			send_text(scwl_pkg::ACT_ART, "a ab abc ");
			if (settings[i] == 6'd63)
				send_text(scwl_pkg::ACT_ART, "abcdefghijklmnopqrstuvwxyzabcdefg ");
		end
		send_item(scwl_pkg::ACT_CLEAR, 8'h00);
		drain();
	endtask

	task automatic random_phase(int items);
		int sent;
		int r;
		string w;
		sent = 0;
		while (sent < items) begin
			r = $urandom_range(99);
			if (r < 15) begin
				w = rand_word($urandom_range(1, 4));
				for (int i = 0; i < w.len(); i++)
					send_item(scwl_pkg::ACT_DICT, $urandom_range(1) ? w[i] - 8'h20 : w[i]);
				if ($urandom_range(9) != 0) begin
					send_item(scwl_pkg::ACT_DICT, scwl_pkg::CH_NL);
					known_words.push_back(w);
				end
				sent += w.len();
			end else if (r < 75) begin
				if (known_words.size() != 0 && $urandom_range(1))
					w = known_words[$urandom_range(known_words.size() - 1)];
				else
					w = rand_word($urandom_range(1, 5));
				for (int i = 0; i < w.len(); i++)
					send_item(scwl_pkg::ACT_ART, $urandom_range(1) ? w[i] - 8'h20 : w[i]);
				send_item(scwl_pkg::ACT_ART, rand_separator());
				sent += w.len() + 1;
			end else if (r < 80) begin
				repeat ($urandom_range(31, 40))
					send_item(scwl_pkg::ACT_ART, rand_letter());
				send_item(scwl_pkg::ACT_END, 8'($urandom_range(255)));
				sent += 10;
			end else if (r < 85) begin
				send_item(scwl_pkg::ACT_END, 8'($urandom_range(255)));
				sent++;
			end else if (r < 88) begin
				send_item(scwl_pkg::ACT_CLEAR, 8'($urandom_range(255)));
				known_words.delete();
				sent++;
			end else if (r < 94) begin
				send_item(scwl_pkg::ACT_DICT, 8'($urandom_range(255)));
				sent++;
			end else begin
				send_item(scwl_pkg::ACT_ART, rand_letter());
				send_item(scwl_pkg::ACT_ART, 8'($urandom_range(255)));
				sent += 2;
			end
		end
		send_item(scwl_pkg::ACT_END, 8'h00);
	endtask

	task automatic test_random();
		send_idle_pct = 0;
		random_phase(20);
		write_min_len(6'd1);
		send_idle_pct = 81;
		random_phase(15);
		write_min_len(6'd3);
		send_idle_pct = 29;
		random_phase(15);
		drain();
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		send_idle_pct = 0;
		fill_cnt = 0;
		word_len = 0;
		word_cut = 0;
		min_len = 6'd2;
		start = 1'b0;
		action = scwl_pkg::ACT_DICT;
		character = 8'h00;
		cfg_we = 1'b0;
		cfg_wdata = 6'd0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_min_length();
		test_random();
		drain();

		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
